/* src/dpbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbt_pkg
// Shared types and constants of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
package dpbt_pkg;

    // Subsample step default
    localparam int SUBSAMPLE_STEP_DEF = 3;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Item kinds
    localparam logic OP_POSE  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Pose storage
    localparam int          POSE_WORDS = 12;
    localparam logic [31:0] POSE_ONE   = 32'd16777216;

    // Configuration register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_RECIP_FX = 3'd2;
    localparam logic [2:0] REG_RECIP_FY = 3'd3;
    localparam logic [2:0] REG_NEAR     = 3'd4;
    localparam logic [2:0] REG_FAR      = 3'd5;

    // Configuration reset values
    localparam logic [15:0] CENTER_X_RST = 16'd5120;
    localparam logic [15:0] CENTER_Y_RST = 16'd3840;
    localparam logic [23:0] RECIP_F_RST  = 24'd31957;
    localparam logic [19:0] NEAR_RST     = 20'd66;
    localparam logic [19:0] FAR_RST      = 20'd327680;

    // Arithmetic widths
    localparam int CAM_W = 34;
    localparam int ACC_W = 48;

    // Queue entry
    typedef struct packed {
        logic        op;
        logic [3:0]  pose_slot;
        logic [31:0] pose_word;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic [19:0] depth_m;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } entry_t;

    // Camera parameters handed to the back end
    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] recip_fx;
        logic [23:0] recip_fy;
    } cam_cfg_t;

    // Reset value of one pose word: identity rotation, zero translation
    function automatic logic [31:0] pose_init(input int idx);
        logic [31:0] w;
        w = '0;
        if (idx == 0 || idx == 5 || idx == 10)
            w = POSE_ONE;
        return w;
    endfunction

endpackage

/* src/dpbt_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbt channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface dpbt_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [3:0]  pose_slot;
    logic signed [31:0] pose_word;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [19:0] depth_m;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;

    modport source (output valid, op, pose_slot, pose_word, pixel_row, pixel_col,
                    depth_m, blue_in, green_in, red_in, input ready);
    modport sink   (input valid, op, pose_slot, pose_word, pixel_row, pixel_col,
                    depth_m, blue_in, green_in, red_in, output ready);
endinterface

interface dpbt_point_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]  blue_out;
    logic [7:0]  green_out;
    logic [7:0]  red_out;

    modport source (output valid, world_x, world_y, world_z, blue_out, green_out,
                    red_out, input ready);
    modport sink   (input valid, world_x, world_y, world_z, blue_out, green_out,
                    red_out, output ready);
endinterface

interface dpbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/dpbt_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbt_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module dpbt_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dpbt_pkg::entry_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output dpbt_pkg::entry_t  head
);
    localparam int PTR_W = $clog2(dpbt_pkg::FIFO_DEPTH);

    dpbt_pkg::entry_t   mem_reg [dpbt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (PTR_W+1)'(dpbt_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into full queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

/* src/dpbt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbt_front
// Accepts items, drops pixels off the subsample grid or outside the depth
// window and pose loads to unused slots, and queues the rest.
// ----------------------------------------------------------------------------
module dpbt_front #(
    parameter int SUBSAMPLE_STEP = dpbt_pkg::SUBSAMPLE_STEP_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    dpbt_item_if.sink         item,
    input  logic [19:0]       near_limit,
    input  logic [19:0]       far_limit,
    input  logic              q_full,
    output logic              q_push,
    output dpbt_pkg::entry_t  q_data
);
    // n is a multiple of the step iff (n * M) mod 2^24 < M, M = ceil(2^24/step)
    localparam logic [24:0] DIV_MAGIC =
        25'((2**24 + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP);

    logic [36:0] row_prod, col_prod;
    logic        on_grid, in_window, keep, xfer;

    assign item.ready = !q_full;
    assign xfer       = item.valid && item.ready;

    // Grid and window test
    always_comb
    begin
        row_prod  = 37'(item.pixel_row) * 37'(DIV_MAGIC);
        col_prod  = 37'(item.pixel_col) * 37'(DIV_MAGIC);
        on_grid   = ({1'b0, row_prod[23:0]} < DIV_MAGIC) &&
                    ({1'b0, col_prod[23:0]} < DIV_MAGIC);
        in_window = (item.depth_m >= near_limit) && (item.depth_m <= far_limit);
        if (item.op == dpbt_pkg::OP_PIXEL)
            keep = on_grid && in_window;
        else
            keep = (item.pose_slot < 4'(dpbt_pkg::POSE_WORDS));
    end

    assign q_push = xfer && keep;

    always_comb
    begin
        q_data.op        = item.op;
        q_data.pose_slot = item.pose_slot;
        q_data.pose_word = item.pose_word;
        q_data.pixel_row = item.pixel_row;
        q_data.pixel_col = item.pixel_col;
        q_data.depth_m   = item.depth_m;
        q_data.blue      = item.blue_in;
        q_data.green     = item.green_in;
        q_data.red       = item.red_in;
    end

`ifndef SYNTHESIS
    a_far_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && item.op == dpbt_pkg::OP_PIXEL && item.depth_m > far_limit)
        |-> !q_push) else $error("far pixel queued");
    a_bad_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && item.op == dpbt_pkg::OP_POSE && item.pose_slot > 4'd11)
        |-> !q_push) else $error("unused pose slot queued");
    a_push_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> xfer) else $error("push without transfer");
`endif

endmodule

/* src/dpbt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbt_back
// Sequencer that back-projects a queued pixel, runs it through the pose one
// multiply-accumulate term at a time, and holds the result in an output
// register. Pose loads are applied in queue order.
// ----------------------------------------------------------------------------
module dpbt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  dpbt_pkg::entry_t  q_head,
    output logic              q_pop,
    input  dpbt_pkg::cam_cfg_t cam_cfg,
    dpbt_point_if.source      point
);
    localparam int CW = dpbt_pkg::CAM_W;
    localparam int AW = dpbt_pkg::ACC_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PROD  = 7'b0000010,
        ST_SCALE = 7'b0000100,
        ST_CAM   = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_ACC   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]         pose_reg [dpbt_pkg::POSE_WORDS];
    logic [3:0]          k_reg;
    logic signed [17:0]  dx_reg, dy_reg;
    logic [19:0]         depth_reg;
    logic [7:0]          blue_reg, green_reg, red_reg;
    logic signed [38:0]  px_reg, py_reg;
    logic signed [51:0]  sxh_reg, sxl_reg, syh_reg, syl_reg;
    logic signed [CW-1:0] camx_reg, camy_reg;
    logic signed [48:0]  prod_hi_reg;
    logic signed [49:0]  prod_lo_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [31:0]  res_reg [3];
    logic                out_valid_reg;
    logic signed [31:0]  wx_reg, wy_reg, wz_reg;
    logic [7:0]          ob_reg, og_reg, or_reg;

    logic signed [63:0]  fullx, fully, roundx, roundy;
    logic signed [CW-1:0] cam_sel;
    logic signed [16:0]  cam_hi;
    logic signed [17:0]  cam_lo;
    logic signed [67:0]  term_full;
    logic signed [AW-1:0] term, acc_sum;
    logic signed [31:0]  acc_sat;
    logic                out_free, row_end, last_term;

    assign out_free  = !out_valid_reg || point.ready;
    assign row_end   = (k_reg[1:0] == 2'd3);
    assign last_term = (k_reg == 4'(dpbt_pkg::POSE_WORDS - 1));
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    // Camera coordinates from scaled products, rounded half up
    always_comb
    begin
        fullx  = (64'(sxh_reg) <<< 12) + 64'(sxl_reg);
        fully  = (64'(syh_reg) <<< 12) + 64'(syl_reg);
        roundx = (fullx + 64'sd134217728) >>> 28;
        roundy = (fully + 64'sd134217728) >>> 28;
    end

    // Operand for the current pose term; the translation column uses 1.0
    always_comb
    begin
        case (k_reg[1:0])
            2'd0:    cam_sel = camx_reg;
            2'd1:    cam_sel = camy_reg;
            2'd2:    cam_sel = CW'($signed({1'b0, depth_reg}));
            default: cam_sel = CW'(65536);
        endcase
        cam_hi = cam_sel[CW-1:17];
        cam_lo = $signed({1'b0, cam_sel[16:0]});
    end

    // Term rounding, accumulation and saturation
    always_comb
    begin
        term_full = (68'(prod_hi_reg) <<< 17) + 68'(prod_lo_reg);
        term      = AW'((term_full + 68'sd8388608) >>> 24);
        acc_sum   = acc_reg + term;
        if (acc_sum > AW'(64'sd2147483647))
            acc_sat = 32'sh7FFFFFFF;
        else if (acc_sum < -AW'(64'sd2147483648))
            acc_sat = 32'sh80000000;
        else
            acc_sat = acc_sum[31:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_head.op == dpbt_pkg::OP_PIXEL)
                    state_next = ST_PROD;
            end
            ST_PROD:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_CAM;
            ST_CAM:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = last_term ? ST_DONE : ST_MUL;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control and pose storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < dpbt_pkg::POSE_WORDS; i++)
                pose_reg[i] <= dpbt_pkg::pose_init(i);
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && q_head.op == dpbt_pkg::OP_POSE)
                pose_reg[q_head.pose_slot] <= q_head.pose_word;
            if (state_reg == ST_CAM)
                k_reg <= '0;
            else if (state_reg == ST_ACC && !last_term)
                k_reg <= k_reg + 1'b1;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (point.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dx_reg    <= $signed({2'b00, q_head.pixel_col, 4'b0000}) -
                         $signed({2'b00, cam_cfg.center_x});
            dy_reg    <= $signed({2'b00, q_head.pixel_row, 4'b0000}) -
                         $signed({2'b00, cam_cfg.center_y});
            depth_reg <= q_head.depth_m;
            blue_reg  <= q_head.blue;
            green_reg <= q_head.green;
            red_reg   <= q_head.red;
        end
        if (state_reg == ST_PROD)
        begin
            px_reg <= dx_reg * $signed({1'b0, depth_reg});
            py_reg <= dy_reg * $signed({1'b0, depth_reg});
        end
        if (state_reg == ST_SCALE)
        begin
            sxh_reg <= px_reg * $signed({1'b0, cam_cfg.recip_fx[23:12]});
            sxl_reg <= px_reg * $signed({1'b0, cam_cfg.recip_fx[11:0]});
            syh_reg <= py_reg * $signed({1'b0, cam_cfg.recip_fy[23:12]});
            syl_reg <= py_reg * $signed({1'b0, cam_cfg.recip_fy[11:0]});
        end
        if (state_reg == ST_CAM)
        begin
            camx_reg <= roundx[CW-1:0];
            camy_reg <= roundy[CW-1:0];
            acc_reg  <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_hi_reg <= $signed(pose_reg[k_reg]) * cam_hi;
            prod_lo_reg <= $signed(pose_reg[k_reg]) * cam_lo;
        end
        if (state_reg == ST_ACC)
        begin
            if (row_end)
            begin
                res_reg[k_reg[3:2]] <= acc_sat;
                acc_reg <= '0;
            end
            else
                acc_reg <= acc_sum;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            wx_reg <= res_reg[0];
            wy_reg <= res_reg[1];
            wz_reg <= res_reg[2];
            ob_reg <= blue_reg;
            og_reg <= green_reg;
            or_reg <= red_reg;
        end
    end

    assign point.valid     = out_valid_reg;
    assign point.world_x   = wx_reg;
    assign point.world_y   = wy_reg;
    assign point.world_z   = wz_reg;
    assign point.blue_out  = ob_reg;
    assign point.green_out = og_reg;
    assign point.red_out   = or_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE)) else $error("pop while busy");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && last_term) |=> (state_reg == ST_DONE))
        else $error("sequence did not finish after last term");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> out_valid_reg)
        else $error("result not presented");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= 4'd11) else $error("term counter out of range");
`endif

endmodule

/* src/depth_pixel_backproject_transform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backproject_transform
// Depth pixel to world point converter: subsample and depth filter, pinhole
// back-projection and 3x4 pose transform.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle whenever its four-entry queue has
// room; pixels off the subsample grid or outside the depth window, and pose
// loads to slots 12..15, are accepted and leave no trace. Queued pose loads
// are applied by the back end when it pops them while idle. A kept pixel
// occupies the back end while it is unloaded, goes through the back-projection
// multiplies and rounding, then through each of the twelve pose terms on the
// single shared multiply-accumulate unit, and is then handed to the output
// register once that register is free. A finished point waits in that register
// while the next pixel is computed. Configuration writes are always ready.
module depth_pixel_backproject_transform #(
    parameter int SUBSAMPLE_STEP = dpbt_pkg::SUBSAMPLE_STEP_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dpbt_item_if.sink     item,
    dpbt_point_if.source  point,
    dpbt_cfg_if.sink      cfg
);
    logic [15:0] center_x_reg, center_y_reg;
    logic [23:0] recip_fx_reg, recip_fy_reg;
    logic [19:0] near_reg, far_reg;

    logic               q_push, q_full, q_pop, q_valid;
    dpbt_pkg::entry_t   q_data, q_head;
    dpbt_pkg::cam_cfg_t cam_cfg;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= dpbt_pkg::CENTER_X_RST;
            center_y_reg <= dpbt_pkg::CENTER_Y_RST;
            recip_fx_reg <= dpbt_pkg::RECIP_F_RST;
            recip_fy_reg <= dpbt_pkg::RECIP_F_RST;
            near_reg     <= dpbt_pkg::NEAR_RST;
            far_reg      <= dpbt_pkg::FAR_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dpbt_pkg::REG_CENTER_X: center_x_reg <= cfg.data[15:0];
                dpbt_pkg::REG_CENTER_Y: center_y_reg <= cfg.data[15:0];
                dpbt_pkg::REG_RECIP_FX: recip_fx_reg <= cfg.data;
                dpbt_pkg::REG_RECIP_FY: recip_fy_reg <= cfg.data;
                dpbt_pkg::REG_NEAR:     near_reg     <= cfg.data[19:0];
                dpbt_pkg::REG_FAR:      far_reg      <= cfg.data[19:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cam_cfg.center_x = center_x_reg;
        cam_cfg.center_y = center_y_reg;
        cam_cfg.recip_fx = recip_fx_reg;
        cam_cfg.recip_fy = recip_fy_reg;
    end

    dpbt_front #(
        .SUBSAMPLE_STEP (SUBSAMPLE_STEP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .near_limit (near_reg),
        .far_limit  (far_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    dpbt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    dpbt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .cam_cfg (cam_cfg),
        .point   (point)
    );

endmodule
